### hw/rtl/itp_pkg.sv
package itp_pkg;

    // Default width of the parsed value.
    localparam int VALUE_W_DEF = 32;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_DONE   = 5'b00001,
        PH_LEAD   = 5'b00010,
        PH_SIGN   = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    // Number bases.
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    // Control handed from the input register to the parser core.
    typedef struct packed {
        logic fire;    // commit this word to the parser state
        logic begins;  // word is the first character of a new string
    } itp_ctl_t;

    // Characters of interest.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Digit value of a character in a base; bit 4 set when it is a valid digit.
    function automatic logic [4:0] digit_decode(input logic [7:0] c, input radix_t rx);
        logic [3:0] d;
        logic       ok;
        d  = 4'd0;
        ok = 1'b0;
        if (c inside {[CH_0:CH_9]}) begin
            d  = 4'(c - CH_0);
            ok = 1'b1;
        end
        else if (c inside {[CH_LO_A:CH_LO_F]}) begin
            d  = 4'(c - CH_LO_A + 8'd10);
            ok = 1'b1;
        end
        else if (c inside {[CH_UP_A:CH_UP_F]}) begin
            d  = 4'(c - CH_UP_A + 8'd10);
            ok = 1'b1;
        end
        case (rx)
            RX_BIN:  ok = ok && (d < 4'd2);
            RX_OCT:  ok = ok && (d < 4'd8);
            RX_DEC:  ok = ok && (d < 4'd10);
            RX_HEX:  ok = ok;
            default: ok = 1'b0;
        endcase
        return {ok, d};
    endfunction

endpackage

### hw/rtl/itp_core.sv
module itp_core #(
    parameter int VALUE_WIDTH = itp_pkg::VALUE_W_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itp_pkg::itp_ctl_t      ctl,
    input  logic [7:0]             symbol,
    output logic                   res_valid,
    output logic [VALUE_WIDTH-1:0] res_value
);
    import itp_pkg::*;

    phase_t                 phase_reg, phase_next;
    radix_t                 radix_reg, radix_next;
    logic                   minus_reg, minus_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    // One parser step on the registered character.
    always_comb
    begin
        logic                   stop;
        logic [4:0]             dig;
        logic [VALUE_WIDTH-1:0] acc_in;
        logic [VALUE_WIDTH-1:0] scaled;

        phase_next = phase_reg;
        radix_next = radix_reg;
        minus_next = minus_reg;
        acc_in     = acc_reg;
        stop       = 1'b0;
        res_valid  = 1'b0;

        // A start abandons any parse in progress.
        if (ctl.begins)
        begin
            phase_next = PH_LEAD;
            radix_next = RX_DEC;
            minus_next = 1'b0;
            acc_in     = '0;
        end

        // Leading spaces and the optional sign.
        if (phase_next == PH_LEAD)
        begin
            stop = 1'b1;
            if (symbol == CH_MINUS)
            begin
                minus_next = 1'b1;
                phase_next = PH_SIGN;
            end
            else if (symbol == CH_PLUS)
            begin
                phase_next = PH_SIGN;
            end
            else if (symbol != CH_SPACE)
            begin
                phase_next = PH_SIGN;
                stop       = 1'b0;
            end
        end

        // Base prefix detection.
        if (!stop)
        begin
            if (phase_next == PH_SIGN)
            begin
                if (symbol == CH_0)
                begin
                    phase_next = PH_ZERO;
                    stop       = 1'b1;
                end
                else
                begin
                    radix_next = RX_DEC;
                    phase_next = PH_DIGITS;
                end
            end
            else if (phase_next == PH_ZERO)
            begin
                phase_next = PH_DIGITS;
                if (symbol == CH_LO_B || symbol == CH_UP_B)
                begin
                    radix_next = RX_BIN;
                    stop       = 1'b1;
                end
                else if (symbol == CH_LO_X || symbol == CH_UP_X)
                begin
                    radix_next = RX_HEX;
                    stop       = 1'b1;
                end
                else
                begin
                    radix_next = RX_OCT;
                end
            end
        end

        // Multiply by the base with shifts; ten is eight plus two.
        case (radix_next)
            RX_BIN:  scaled = acc_in << 1;
            RX_OCT:  scaled = acc_in << 3;
            RX_HEX:  scaled = acc_in << 4;
            default: scaled = (acc_in << 3) + (acc_in << 1);
        endcase

        // Digit accumulation, or the end of the number.
        dig        = digit_decode(symbol, radix_next);
        acc_next   = acc_in;
        res_value  = minus_next ? (VALUE_WIDTH'(0) - acc_in) : acc_in;
        if (!stop && phase_next == PH_DIGITS)
        begin
            if (dig[4])
            begin
                acc_next = scaled + VALUE_WIDTH'(dig[3:0]);
            end
            else
            begin
                res_valid  = 1'b1;
                phase_next = PH_DONE;
            end
        end
        res_valid = res_valid && ctl.fire;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            radix_reg <= RX_DEC;
            minus_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else if (ctl.fire)
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            minus_reg <= minus_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

### hw/rtl/integer_text_parser_auto_base.sv
// Channel | Direction | tdata (low bit up)        | tuser  | Words
// s_      | in        | symbol[7:0]               | begins | one character each
// m_      | out       | value[VALUE_WIDTH-1:0]    | -      | zero or one per character
//
// Each character is one parser step; a new word is taken every cycle unless a stalled output word holds the input.
// A character passes through the input register, then the parser step into the output register.
// Reset clears the valid flags and puts the parser in the done phase.
// A stalled output word stops the parser only when the next character is ready to step.
module integer_text_parser_auto_base #(
    parameter int VALUE_WIDTH = itp_pkg::VALUE_W_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // symbol[7:0]
    input  logic                                  s_tuser,   // begins
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata // value, zero padded
);
    import itp_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_symbol_reg;
    logic                   in_begins_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_free;
    logic                   step_fire;
    itp_ctl_t               ctl;
    logic                   res_valid;
    logic [VALUE_WIDTH-1:0] res_value;

    // Handshake control.
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || step_fire;
    assign ctl.fire   = step_fire;
    assign ctl.begins = in_begins_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_symbol_reg <= s_tdata;
            in_begins_reg <= s_tuser;
        end
    end

    // Parser step.
    itp_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .symbol    (in_symbol_reg),
        .res_valid (res_valid),
        .res_value (res_value)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_value_reg <= res_value;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata                    = '0;
        m_tdata[VALUE_WIDTH-1:0] = out_value_reg;
    end

    // Input backpressure only comes from a held character behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a stalled output word");

    // A result produced by the parser shows up on the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_tvalid)
        else $error("parser result lost");

    // The parser never steps over an output word that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !step_fire)
        else $error("parser stepped while output stalled");

endmodule

### tb/integer_text_parser_auto_base_test.sv
`timescale 1ns / 100ps

import itp_pkg::*;

typedef logic [VALUE_W_DEF-1:0] parsed_value_t;

// Tracks the parser state for every accepted character and holds the values still due.
class parse_scoreboard;
    phase_t        phase;
    radix_t        radix;
    bit            minus_seen;
    parsed_value_t acc;
    parsed_value_t due_values[$];
    int            errors;

    function new();
        phase      = PH_DONE;
        radix      = RX_DEC;
        minus_seen = 1'b0;
        acc        = '0;
        errors     = 0;
    endfunction

    // Numeric weight of a character in the current base, or -1 if it is no digit there.
    function int digit_weight(logic [7:0] c);
        int d;
        int base;
        d = -1;
        if (c >= CH_0 && c <= CH_9)
            d = int'(c - CH_0);
        else if (c >= CH_LO_A && c <= CH_LO_F)
            d = int'(c - CH_LO_A) + 10;
        else if (c >= CH_UP_A && c <= CH_UP_F)
            d = int'(c - CH_UP_A) + 10;
        case (radix)
            RX_BIN:  base = 2;
            RX_OCT:  base = 8;
            RX_HEX:  base = 16;
            default: base = 10;
        endcase
        if (d >= base)
            d = -1;
        return d;
    endfunction

    function int base_of();
        case (radix)
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            RX_HEX:  return 16;
            default: return 10;
        endcase
    endfunction

    // Steps the parser by one accepted word; returns 1 when the word belonged to a live parse.
    function bit note_symbol(logic [7:0] c, bit begins);
        bit live;
        int d;
        live = begins || (phase != PH_DONE);
        if (begins)
        begin
            phase      = PH_LEAD;
            radix      = RX_DEC;
            minus_seen = 1'b0;
            acc        = '0;
        end

        // Leading spaces and the optional sign.
        if (phase == PH_LEAD)
        begin
            if (c == CH_SPACE)
                return live;
            if (c == CH_MINUS)
            begin
                minus_seen = 1'b1;
                phase      = PH_SIGN;
                return live;
            end
            if (c == CH_PLUS)
            begin
                phase = PH_SIGN;
                return live;
            end
            phase = PH_SIGN;
        end

        // Base detection from a leading zero and the prefix letter.
        if (phase == PH_SIGN)
        begin
            if (c == CH_0)
            begin
                phase = PH_ZERO;
                return live;
            end
            radix = RX_DEC;
            phase = PH_DIGITS;
        end
        else if (phase == PH_ZERO)
        begin
            if (c == CH_LO_B || c == CH_UP_B)
            begin
                radix = RX_BIN;
                phase = PH_DIGITS;
                return live;
            end
            if (c == CH_LO_X || c == CH_UP_X)
            begin
                radix = RX_HEX;
                phase = PH_DIGITS;
                return live;
            end
            radix = RX_OCT;
            phase = PH_DIGITS;
        end

        if (phase != PH_DIGITS)
            return live;

        // Accumulate a digit, or end the parse on anything else.
        d = digit_weight(c);
        if (d >= 0)
        begin
            acc = parsed_value_t'(acc * base_of() + d);
            return live;
        end
        due_values.push_back(minus_seen ? parsed_value_t'(-acc) : acc);
        phase = PH_DONE;
        return live;
    endfunction

    function int pending();
        return due_values.size();
    endfunction

    // Compares one output word with the oldest value due.
    function void check_value(parsed_value_t actual);
        parsed_value_t wanted;
        if (due_values.size() == 0)
        begin
            $error("value: expected no word, actual %0d", $signed(actual));
            errors++;
            return;
        end
        wanted = due_values.pop_front();
        if (wanted !== actual)
        begin
            $error("value: expected %0d, actual %0d", $signed(wanted), $signed(actual));
            errors++;
        end
    endfunction
endclass

module integer_text_parser_auto_base_test;

    localparam int VW          = VALUE_W_DEF;
    localparam int DW          = ((VW + 7) / 8) * 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int ITEM_TARGET = 600;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;    // symbol[7:0]
    logic          s_tuser;    // begins
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;    // value

    parse_scoreboard sb = new();

    bit steady;
    int live_items;
    int idle_cycles;

    integer_text_parser_auto_base #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Drives one character word and waits until it is accepted.
    task automatic send_symbol(input logic [7:0] sym, input bit begins);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= begins;
        do
            @(posedge clk);
        while (!s_tready);
        if (sb.note_symbol(sym, begins))
            live_items++;
    endtask

    // Sends a string as a new start, then an optional trailing byte.
    task automatic send_text(input string body, input int tail);
        for (int i = 0; i < body.len(); i++)
            send_symbol(body[i], i == 0);
        if (tail >= 0)
            send_symbol(8'(tail), body.len() == 0);
    endtask

    // Builds one random string: mostly well-formed numbers, some noise and broken ones.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         spaces;
        int         prefix;
        int         ndigits;
        int         ending;
        int         v;
        int         base;
        text.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: random bytes with occasional starts.
            repeat ($urandom_range(1, 6))
                send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            return;
        end

        spaces = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (spaces)
            text.push_back(CH_SPACE);
        case ($urandom_range(0, 2))
            1: text.push_back(CH_MINUS);
            2: text.push_back(CH_PLUS);
            default: ;
        endcase

        prefix = $urandom_range(0, 3);
        case (prefix)
            1:
            begin
                text.push_back(CH_0);
                base = 8;
            end
            2:
            begin
                text.push_back(CH_0);
                text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                base = 16;
            end
            3:
            begin
                text.push_back(CH_0);
                text.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                base = 2;
            end
            default: base = 10;
        endcase

        // Long digit runs now and then, so the accumulator wraps.
        ndigits = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        repeat (ndigits)
        begin
            v = $urandom_range(0, base - 1);
            if (v < 10)
                text.push_back(8'(CH_0 + v));
            else if ($urandom_range(0, 1))
                text.push_back(8'(CH_LO_A + v - 10));
            else
                text.push_back(8'(CH_UP_A + v - 10));
        end

        // Terminator: NUL, a random byte, a space, or none at all.
        ending = $urandom_range(0, 9);
        if (ending <= 4)
            text.push_back(8'h00);
        else if (ending <= 7)
            text.push_back(8'($urandom_range(0, 255)));
        else if (ending == 8)
            text.push_back(CH_SPACE);

        // Trailing bytes after the end of the parse.
        repeat ($urandom_range(0, 2))
            text.push_back(8'($urandom_range(0, 255)));

        foreach (text[i])
            send_symbol(text[i], i == 0);
    endtask

    // Output side: random stalls per word, each accepted word checked at the rising edge.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_value(m_tdata[VW-1:0]);
        end
    end

    // Reset, directed strings, random strings, drain.
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        steady      = 1'b0;
        live_items  = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Space, minus, hex digits in both cases, byte 255 ending it, then an ignored byte.
        send_text(" -0x1fA", 8'hFF);
        send_symbol("z", 1'b0);
        // Plus sign, upper-case binary prefix, NUL terminator.
        send_text("+0B1", 8'h00);
        // Octal digits, then an 8 or 9 ending the parse.
        send_text("079", -1);
        send_text("08", -1);
        // Space right after the sign.
        send_text("- ", -1);
        // Hex prefix with no digits.
        send_text("0x", 8'h00);
        // New start abandons an unfinished parse.
        send_text("12", -1);
        send_text("9", 8'h00);
        // NUL before any digit.
        send_text("", 8'h00);

        live_items = 0;
        while (live_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
                steady = !steady;
            send_random_string();
        end
        steady = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
